// ===== rtl/sbh_pkg.sv =====
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types, constants and round functions of the SHA-256 block hash core.
// ----------------------------------------------------------------------------
package sbh_pkg;

   localparam int WORD_W   = 32;
   localparam int ROUNDS   = 64;
   localparam int ROUND_W  = $clog2(ROUNDS);
   localparam int BLOCK_W  = 16;
   localparam int CNT_W    = $clog2(BLOCK_W);
   localparam int DIGEST_N = 8;
   localparam int IDX_W    = $clog2(DIGEST_N);

   localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(ROUNDS - 1);
   localparam logic [CNT_W-1:0]   LAST_WORD   = CNT_W'(BLOCK_W - 1);
   localparam logic [IDX_W-1:0]   LAST_DIGEST = IDX_W'(DIGEST_N - 1);

   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               load_word;
      logic               start;
      logic               round;
      logic               update;
      logic               emit;
      logic               emit_last;
      logic [ROUND_W-1:0] round_idx;
      logic [IDX_W-1:0]   emit_idx;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   localparam logic [WORD_W-1:0] H_INIT [DIGEST_N] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   function automatic logic [WORD_W-1:0] choose(input logic [WORD_W-1:0] e,
                                                input logic [WORD_W-1:0] f,
                                                input logic [WORD_W-1:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [WORD_W-1:0] majority(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b,
                                                  input logic [WORD_W-1:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

// ===== rtl/sha256_block_hash_top.sv =====
// ----------------------------------------------------------------------------
// sha256_block_hash_top
// SHA-256 block hash core: collects padded 32-bit message words, compresses
// every 16-word block into the chaining state, emits the digest on finish.
//
//   channel   ports                                        direction
//   req       req_valid req_stall req_kind req_word        in
//   rsp       rsp_valid rsp_stall rsp_digest_word          out
//             rsp_word_number rsp_last
//
// a message word is taken whenever the core is idle; the sixteenth word of a
// block is followed by the 64 rounds of the single round unit and one chain
// update, with req_stall high throughout
// a finish is followed by eight digest transfers, one per cycle
// while rsp_stall is low; the next word may enter while the last one waits
// reset loads the initial hash values directly, no clearing pass
// ----------------------------------------------------------------------------
module sha256_block_hash_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic [sbh_pkg::WORD_W-1:0]   req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sbh_pkg::WORD_W-1:0]   rsp_digest_word,
   output logic [sbh_pkg::IDX_W-1:0]    rsp_word_number,
   output logic                         rsp_last
);

   sbh_pkg::cmd_type    cmd;
   sbh_pkg::status_type status;

   sbh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   sbh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_word        (req_word),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_number (rsp_word_number),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== rtl/sbh_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbh_ctrl
// Controller: counts message words, sequences the 64 rounds, the chain update
// and the eight digest transfers.
// ----------------------------------------------------------------------------
module sbh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   input  sbh_pkg::status_type  status,
   output logic                 req_stall,
   output sbh_pkg::cmd_type     cmd
);

   sbh_pkg::state_type               state_ff, state_in;
   logic [sbh_pkg::CNT_W-1:0]        word_cnt_ff, word_cnt_in;
   logic [sbh_pkg::ROUND_W-1:0]      count_ff, count_in;
   logic                             finish_acc;

   assign finish_acc = (state_ff == sbh_pkg::ST_IDLE) && req_valid
                       && (req_kind == sbh_pkg::KIND_FINISH);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbh_pkg::ST_IDLE: begin
            if (finish_acc) begin
               state_in = sbh_pkg::ST_EMIT;
            end else if (req_valid && word_cnt_ff == sbh_pkg::LAST_WORD) begin
               state_in = sbh_pkg::ST_ROUND;
            end
         end
         sbh_pkg::ST_ROUND: begin
            if (count_ff == sbh_pkg::LAST_ROUND) begin
               state_in = sbh_pkg::ST_UPDATE;
            end
         end
         sbh_pkg::ST_UPDATE: begin
            state_in = sbh_pkg::ST_IDLE;
         end
         sbh_pkg::ST_EMIT: begin
            if (status.out_free && count_ff[sbh_pkg::IDX_W-1:0] == sbh_pkg::LAST_DIGEST) begin
               state_in = sbh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbh_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = (state_ff != sbh_pkg::ST_IDLE);
      cmd           = '0;
      cmd.round_idx = count_ff;
      cmd.emit_idx  = count_ff[sbh_pkg::IDX_W-1:0];
      case (state_ff)
         sbh_pkg::ST_IDLE: begin
            cmd.load_word = req_valid && (req_kind == sbh_pkg::KIND_WORD);
            cmd.start     = cmd.load_word && (word_cnt_ff == sbh_pkg::LAST_WORD);
         end
         sbh_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
         end
         sbh_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         sbh_pkg::ST_EMIT: begin
            cmd.emit      = status.out_free;
            cmd.emit_last = status.out_free
                            && (count_ff[sbh_pkg::IDX_W-1:0] == sbh_pkg::LAST_DIGEST);
         end
         default: begin
            cmd.load_word = 1'b0;
         end
      endcase
   end

   // counters
   always_comb begin
      word_cnt_in = word_cnt_ff;
      count_in    = count_ff;
      if (finish_acc) begin
         word_cnt_in = '0;
         count_in    = '0;
      end else if (cmd.load_word) begin
         word_cnt_in = word_cnt_ff + 1'b1;
      end
      if (cmd.start) begin
         count_in = '0;
      end else if (cmd.round || cmd.emit) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sbh_pkg::ST_IDLE;
         word_cnt_ff <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         word_cnt_ff <= word_cnt_in;
         count_ff    <= count_in;
      end
   end

   a_block_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == sbh_pkg::ST_ROUND) && (count_ff == '0))
      else $error("sixteenth word did not start the rounds at round zero");

   a_last_round_updates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbh_pkg::ST_ROUND) && (count_ff == sbh_pkg::LAST_ROUND)
      |=> (state_ff == sbh_pkg::ST_UPDATE))
      else $error("chain update did not follow the last round");

   a_update_ends_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbh_pkg::ST_UPDATE) |=> (state_ff == sbh_pkg::ST_IDLE)
      && (word_cnt_ff == '0))
      else $error("block did not end with an empty word count");

   a_finish_clears_count: assert property (@(posedge clock) disable iff (reset)
      finish_acc |=> (state_ff == sbh_pkg::ST_EMIT) && (word_cnt_ff == '0)
      && (count_ff == '0))
      else $error("finish did not clear the word count");

   a_emit_last_idles: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_last |=> (state_ff == sbh_pkg::ST_IDLE))
      else $error("controller stayed busy after the last digest word");

endmodule

// ===== rtl/sbh_datapath.sv =====
// ----------------------------------------------------------------------------
// sbh_datapath
// Datapath: message schedule window, working variables, chaining state and
// the registered digest output.
// ----------------------------------------------------------------------------
module sbh_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  sbh_pkg::cmd_type             cmd,
   input  logic [sbh_pkg::WORD_W-1:0]   req_word,
   input  logic                         rsp_stall,
   output sbh_pkg::status_type          status,
   output logic                         rsp_valid,
   output logic [sbh_pkg::WORD_W-1:0]   rsp_digest_word,
   output logic [sbh_pkg::IDX_W-1:0]    rsp_word_number,
   output logic                         rsp_last
);

   logic [sbh_pkg::WORD_W-1:0] win_ff   [sbh_pkg::BLOCK_W];
   logic [sbh_pkg::WORD_W-1:0] win_in   [sbh_pkg::BLOCK_W];
   logic [sbh_pkg::WORD_W-1:0] work_ff  [sbh_pkg::DIGEST_N];
   logic [sbh_pkg::WORD_W-1:0] work_in  [sbh_pkg::DIGEST_N];
   logic [sbh_pkg::WORD_W-1:0] chain_ff [sbh_pkg::DIGEST_N];
   logic [sbh_pkg::WORD_W-1:0] chain_in [sbh_pkg::DIGEST_N];

   logic [sbh_pkg::WORD_W-1:0] sched_new;
   logic [sbh_pkg::WORD_W-1:0] t1;
   logic [sbh_pkg::WORD_W-1:0] t2;

   logic                       out_valid_ff;
   logic [sbh_pkg::WORD_W-1:0] out_word_ff;
   logic [sbh_pkg::IDX_W-1:0]  out_num_ff;
   logic                       out_last_ff;

   assign sched_new = sbh_pkg::small_sigma1(win_ff[14]) + win_ff[9]
                      + sbh_pkg::small_sigma0(win_ff[1]) + win_ff[0];

   assign t1 = work_ff[7] + sbh_pkg::big_sigma1(work_ff[4])
               + sbh_pkg::choose(work_ff[4], work_ff[5], work_ff[6])
               + sbh_pkg::ROUND_K[cmd.round_idx] + win_ff[0];

   assign t2 = sbh_pkg::big_sigma0(work_ff[0])
               + sbh_pkg::majority(work_ff[0], work_ff[1], work_ff[2]);

   // schedule window, oldest word at entry zero
   always_comb begin
      win_in = win_ff;
      if (cmd.load_word || cmd.round) begin
         for (int i = 0; i < sbh_pkg::BLOCK_W - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[sbh_pkg::BLOCK_W-1] = cmd.load_word ? req_word : sched_new;
      end
   end

   // working variables a to h
   always_comb begin
      work_in = work_ff;
      if (cmd.start) begin
         work_in = chain_ff;
      end else if (cmd.round) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end
   end

   // chaining state: block update, one word out per transfer, H_INIT at last
   always_comb begin
      chain_in = chain_ff;
      if (cmd.update) begin
         for (int i = 0; i < sbh_pkg::DIGEST_N; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end else if (cmd.emit_last) begin
         chain_in = sbh_pkg::H_INIT;
      end else if (cmd.emit) begin
         for (int i = 0; i < sbh_pkg::DIGEST_N - 1; i++) begin
            chain_in[i] = chain_ff[i+1];
         end
         chain_in[sbh_pkg::DIGEST_N-1] = chain_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
      if (cmd.emit) begin
         out_word_ff <= chain_ff[0];
         out_num_ff  <= cmd.emit_idx;
         out_last_ff <= cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff     <= sbh_pkg::H_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !out_valid_ff || !rsp_stall;
   assign rsp_valid       = out_valid_ff;
   assign rsp_digest_word = out_word_ff;
   assign rsp_word_number = out_num_ff;
   assign rsp_last        = out_last_ff;

endmodule

// ===== tb/tb_sha256_block_hash_top.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_block_hash_top
// Self-checking bench for the SHA-256 block hash core. Random message words
// and finish requests go in with random idle cycles and random output stalls,
// plus one long output hold-off that backs the core up. A built-in SHA-256
// tracker computes each digest, and every digest word transfer is compared
// field by field against it.
// ----------------------------------------------------------------------------
module tb_sha256_block_hash_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET    = 310;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 100;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [sbh_pkg::WORD_W-1:0] SHA_INIT [sbh_pkg::DIGEST_N] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [sbh_pkg::WORD_W-1:0] SHA_K [sbh_pkg::ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct packed {
      logic [sbh_pkg::WORD_W-1:0] digest_word;
      logic [sbh_pkg::IDX_W-1:0]  word_number;
      logic                       last;
   } digest_beat_type;

   class sha256_digest_tracker_type;
      logic [sbh_pkg::WORD_W-1:0] chain [sbh_pkg::DIGEST_N];
      logic [sbh_pkg::WORD_W-1:0] window [sbh_pkg::BLOCK_W];
      int unsigned                fill;
      digest_beat_type            digests_due [$];
      int unsigned                errors;

      function new();
         chain  = SHA_INIT;
         fill   = 0;
         errors = 0;
      endfunction

      function logic [sbh_pkg::WORD_W-1:0] ror(input logic [sbh_pkg::WORD_W-1:0] x,
                                               input int n);
         return (x >> n) | (x << (sbh_pkg::WORD_W - n));
      endfunction

      function void compress_block();
         logic [sbh_pkg::WORD_W-1:0] v [sbh_pkg::DIGEST_N];
         logic [sbh_pkg::WORD_W-1:0] t1, t2, e, a, w1, w14;
         int s;
         v = chain;
         for (int r = 0; r < sbh_pkg::ROUNDS; r++) begin
            s = r % sbh_pkg::BLOCK_W;
            e = v[4];
            a = v[0];
            if (r >= sbh_pkg::BLOCK_W) begin
               w1  = window[(s + 1) % sbh_pkg::BLOCK_W];
               w14 = window[(s + 14) % sbh_pkg::BLOCK_W];
               window[s] = window[s] + (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10))
                         + window[(s + 9) % sbh_pkg::BLOCK_W]
                         + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3));
            end
            t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
               + ((e & v[5]) ^ (~e & v[6])) + SHA_K[r] + window[s];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
               + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
            for (int i = sbh_pkg::DIGEST_N - 1; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
         end
         for (int i = 0; i < sbh_pkg::DIGEST_N; i++) chain[i] = chain[i] + v[i];
      endfunction

      function void take_request(input logic kind,
                                 input logic [sbh_pkg::WORD_W-1:0] word);
         digest_beat_type beat;
         if (kind == sbh_pkg::KIND_WORD) begin
            window[fill] = word;
            fill = (fill + 1) % sbh_pkg::BLOCK_W;
            if (fill == 0) compress_block();
         end else begin
            for (int i = 0; i < sbh_pkg::DIGEST_N; i++) begin
               beat.digest_word = chain[i];
               beat.word_number = sbh_pkg::IDX_W'(i);
               beat.last        = (i == sbh_pkg::DIGEST_N - 1);
               digests_due.push_back(beat);
            end
            chain = SHA_INIT;
            fill  = 0;
         end
      endfunction

      function void check_digest(input digest_beat_type got);
         digest_beat_type want;
         if (digests_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected digest transfer, expected none, actual word %h",
                     $time, got.digest_word);
            return;
         end
         want = digests_due.pop_front();
         if (got.digest_word !== want.digest_word) begin
            errors++;
            $display("%0t: digest_word expected %h actual %h",
                     $time, want.digest_word, got.digest_word);
         end
         if (got.word_number !== want.word_number) begin
            errors++;
            $display("%0t: word_number expected %0d actual %0d",
                     $time, want.word_number, got.word_number);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_kind = sbh_pkg::KIND_WORD;
   logic [sbh_pkg::WORD_W-1:0] req_word = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [sbh_pkg::WORD_W-1:0] rsp_digest_word;
   logic [sbh_pkg::IDX_W-1:0]  rsp_word_number;
   logic                       rsp_last;

   bit                steady = 1'b0;
   bit                hold_off_go = 1'b0;
   int unsigned       items_taken = 0;
   int unsigned       quiet_cycles = 0;

   sha256_digest_tracker_type digest_tracker = new();

   sha256_block_hash_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_number (rsp_word_number),
      .rsp_last        (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_item(input logic kind, input logic [sbh_pkg::WORD_W-1:0] word);
      while (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_word  <= word;
      do @(posedge clock); while (req_stall !== 1'b0);
      digest_tracker.take_request(kind, word);
      items_taken++;
   endtask

   task automatic send_message(input int blocks, input int extra, input bit hold_at_finish);
      repeat (blocks * sbh_pkg::BLOCK_W + extra) send_item(sbh_pkg::KIND_WORD, $urandom());
      if (hold_at_finish) hold_off_go = 1'b1;
      send_item(sbh_pkg::KIND_FINISH, $urandom());
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !steady && ($urandom_range(99) < 28);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         digest_tracker.check_digest({rsp_digest_word, rsp_word_number, rsp_last});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("sha256_block_hash_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int msg;
      int extra;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // finish with no blocks gives the initial values
      send_item(sbh_pkg::KIND_FINISH, 32'hffffffff);
      // one block of extreme words
      for (int i = 0; i < sbh_pkg::BLOCK_W; i++)
         send_item(sbh_pkg::KIND_WORD, i[0] ? 32'h0 : 32'hffffffff);
      send_item(sbh_pkg::KIND_FINISH, 32'h0);
      // partial block is dropped at finish
      repeat (3) send_item(sbh_pkg::KIND_WORD, 32'hffffffff);
      send_item(sbh_pkg::KIND_FINISH, $urandom());

      msg = 0;
      while (items_taken < ITEM_TARGET) begin
         steady = (msg >= 3 && msg < 6);
         extra  = ($urandom_range(99) < 25) ? $urandom_range(15, 1) : 0;
         send_message($urandom_range(2, 0), extra, msg == 7);
         msg++;
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (digest_tracker.digests_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (digest_tracker.errors == 0 && digest_tracker.digests_due.size() == 0) begin
         $display("sha256_block_hash_top test passed");
      end else begin
         $display("sha256_block_hash_top test failed");
      end
      $finish;
   end

endmodule
